@@ rtl/tcce_pkg.sv @@
// Shared types and constants for the text console cursor engine.
package tcce_pkg;

  // Cell index width, wide enough for the largest screen geometry.
  localparam int CELL_W = 16;
  localparam int COL_W  = 8;
  localparam int OUT_W  = 11;

  // Input function codes.
  localparam logic [2:0] FUNC_PLAIN  = 3'd0;
  localparam logic [2:0] FUNC_STYLED = 3'd1;
  localparam logic [2:0] FUNC_POS    = 3'd2;
  localparam logic [2:0] FUNC_SETCUR = 3'd3;
  localparam logic [2:0] FUNC_CLEAR  = 3'd4;

  // Special character bytes.
  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  // Classified operation carried from front to back.
  typedef enum logic [2:0] {
    OP_CHAR,
    OP_BS,
    OP_NL,
    OP_STYLED,
    OP_POS,
    OP_SETCUR,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [7:0]        ch;
    logic [7:0]        sty;
    logic              last;
    logic              tgt_ok;
    logic [CELL_W-1:0] tgt_cell;
    logic [COL_W-1:0]  tgt_col;
  } cmd_t;

  typedef struct packed {
    logic [OUT_W-1:0] start_cell;
    logic [OUT_W-1:0] fill_count;
    logic [7:0]       cell_char;
    logic             write_style;
    logic [7:0]       cell_style;
    logic [OUT_W-1:0] cursor_after;
  } res_t;

endpackage

@@ rtl/tcce_fifo.sv @@
// Two-entry word queue used between the engine stages.
module tcce_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);
  logic [W-1:0] mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         do_push;
  logic         do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      if (do_push && !do_pop)      count <= count + 2'd1;
      else if (do_pop && !do_push) count <= count - 2'd1;
    end
  end
endmodule

@@ rtl/tcce_front.sv @@
// Front end: decodes an incoming command word and resolves its target cell.
module tcce_front #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic [2:0]    func,
  input  logic [7:0]    char_code,
  input  logic [7:0]    style,
  input  logic [7:0]    row,
  input  logic [7:0]    col,
  input  logic          last,
  output tcce_pkg::cmd_t cmd
);
  import tcce_pkg::*;

  localparam logic [7:0] ROWS_C = 8'(ROWS);
  localparam logic [7:0] COLS_C = 8'(COLUMNS);

  logic [CELL_W-1:0] row_base;

  // row * COLUMNS, one narrow constant multiply
  assign row_base = CELL_W'(row) * CELL_W'(COLUMNS);

  always_comb begin
    cmd.ch       = char_code;
    cmd.sty      = style;
    cmd.last     = last;
    cmd.tgt_ok   = (row < ROWS_C) && (col < COLS_C);
    cmd.tgt_cell = row_base + CELL_W'(col);
    cmd.tgt_col  = col;
    case (func)
      FUNC_PLAIN: begin
        if (char_code == CHAR_BS)      cmd.op = OP_BS;
        else if (char_code == CHAR_NL) cmd.op = OP_NL;
        else                           cmd.op = OP_CHAR;
      end
      FUNC_STYLED: cmd.op = OP_STYLED;
      FUNC_POS:    cmd.op = OP_POS;
      FUNC_SETCUR: cmd.op = OP_SETCUR;
      FUNC_CLEAR:  cmd.op = OP_CLEAR;
      default:     cmd.op = OP_NOP;
    endcase
  end
endmodule

@@ rtl/tcce_back.sv @@
// Back end: holds cursor state and turns each command into one cell-write run.
module tcce_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           take,
  input  tcce_pkg::cmd_t cmd,
  output tcce_pkg::res_t res
);
  import tcce_pkg::*;

  localparam logic [CELL_W-1:0] CELLS    = CELL_W'(ROWS * COLUMNS);
  localparam logic [CELL_W-1:0] COLS_C   = CELL_W'(COLUMNS);
  localparam logic [COL_W-1:0]  LAST_COL = COL_W'(COLUMNS - 1);

  logic [CELL_W-1:0] cursor, cursor_next;
  logic [COL_W-1:0]  cur_col, cur_col_next;
  logic [CELL_W-1:0] saved_cursor, saved_cursor_next;
  logic [COL_W-1:0]  saved_col, saved_col_next;
  logic              in_positioned, in_positioned_next;
  logic              drop_string, drop_string_next;

  logic [CELL_W-1:0] w_start;
  logic [CELL_W-1:0] w_count;
  logic [7:0]        w_char;
  logic              w_style;
  logic [7:0]        w_sty;
  logic [CELL_W-1:0] nl_len;

  // Command execution, steps applied in order on working copies
  always_comb begin
    cursor_next        = cursor;
    cur_col_next       = cur_col;
    saved_cursor_next  = saved_cursor;
    saved_col_next     = saved_col;
    in_positioned_next = in_positioned;
    drop_string_next   = drop_string;
    w_start = '0;
    w_count = '0;
    w_char  = CHAR_NUL;
    w_style = 1'b0;
    w_sty   = 8'h00;
    nl_len  = '0;

    // close an open string first unless this continues it
    if (cmd.op != OP_NOP &&
        !(cmd.op == OP_STYLED && !in_positioned) &&
        !(cmd.op == OP_POS && in_positioned)) begin
      if (in_positioned) begin
        cursor_next  = saved_cursor;
        cur_col_next = saved_col;
      end else if (cursor >= CELLS) begin
        cursor_next  = '0;
        cur_col_next = '0;
      end
      in_positioned_next = 1'b0;
      drop_string_next   = 1'b0;
    end

    // positioned string opens: save cursor and jump
    if (cmd.op == OP_POS && !in_positioned) begin
      saved_cursor_next  = cursor_next;
      saved_col_next     = cur_col_next;
      in_positioned_next = 1'b1;
      if (cmd.tgt_ok) begin
        cursor_next  = cmd.tgt_cell;
        cur_col_next = cmd.tgt_col;
      end else begin
        drop_string_next = 1'b1;
      end
    end

    case (cmd.op)
      OP_CHAR: begin
        w_start = cursor_next;
        w_count = CELL_W'(1);
        w_char  = cmd.ch;
        cursor_next  = cursor_next + CELL_W'(1);
        cur_col_next = (cur_col_next == LAST_COL) ? '0 : cur_col_next + COL_W'(1);
      end
      OP_BS: begin
        if (cursor_next != '0) begin
          cursor_next  = cursor_next - CELL_W'(1);
          cur_col_next = (cur_col_next == '0) ? LAST_COL : cur_col_next - COL_W'(1);
          w_start = cursor_next;
          w_count = CELL_W'(1);
          w_char  = CHAR_NUL;
        end
      end
      OP_NL: begin
        nl_len  = COLS_C - CELL_W'(cur_col_next);
        w_start = cursor_next;
        w_count = nl_len;
        w_char  = CHAR_SPACE;
        cursor_next  = cursor_next + nl_len;
        cur_col_next = '0;
      end
      OP_STYLED, OP_POS: begin
        if (drop_string_next || cursor_next >= CELLS) begin
          drop_string_next = 1'b1;
        end else begin
          w_start = cursor_next;
          w_count = CELL_W'(1);
          w_char  = cmd.ch;
          w_style = 1'b1;
          w_sty   = cmd.sty;
          cursor_next  = cursor_next + CELL_W'(1);
          cur_col_next = (cur_col_next == LAST_COL) ? '0 : cur_col_next + COL_W'(1);
          if (cursor_next >= CELLS) drop_string_next = 1'b1;
        end
        // last character closes the string
        if (cmd.last) begin
          if (in_positioned_next) begin
            cursor_next  = saved_cursor_next;
            cur_col_next = saved_col_next;
          end else if (cursor_next >= CELLS) begin
            cursor_next  = '0;
            cur_col_next = '0;
          end
          in_positioned_next = 1'b0;
          drop_string_next   = 1'b0;
        end
      end
      OP_SETCUR: begin
        if (cmd.tgt_ok) begin
          cursor_next  = cmd.tgt_cell;
          cur_col_next = cmd.tgt_col;
        end
      end
      OP_CLEAR: begin
        w_start = '0;
        w_count = CELLS;
        w_char  = CHAR_SPACE;
        cursor_next  = '0;
        cur_col_next = '0;
      end
      default: begin
      end
    endcase

    // plain output wraps the cursor at the screen end
    if ((cmd.op == OP_CHAR || cmd.op == OP_BS || cmd.op == OP_NL) &&
        cursor_next >= CELLS) begin
      cursor_next  = '0;
      cur_col_next = '0;
    end
  end

  // Result word
  always_comb begin
    res.start_cell   = w_start[OUT_W-1:0];
    res.fill_count   = w_count[OUT_W-1:0];
    res.cell_char    = w_char;
    res.write_style  = w_style;
    res.cell_style   = w_sty;
    res.cursor_after = cursor_next[OUT_W-1:0];
  end

  // Cursor state
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor        <= '0;
      cur_col       <= '0;
      saved_cursor  <= '0;
      saved_col     <= '0;
      in_positioned <= 1'b0;
      drop_string   <= 1'b0;
    end else if (take) begin
      cursor        <= cursor_next;
      cur_col       <= cur_col_next;
      saved_cursor  <= saved_cursor_next;
      saved_col     <= saved_col_next;
      in_positioned <= in_positioned_next;
      drop_string   <= drop_string_next;
    end
  end
endmodule

@@ rtl/text_console_cursor_engine.sv @@
// Top level of the text console cursor engine.
//
//   channel  | handshake        | payload
//   ---------+------------------+-----------------------------------------------
//   command  | push / full      | func, char_code, style, row, col, last
//   result   | pop / empty      | start_cell, fill_count, cell_char,
//            |                  | write_style, cell_style, cursor_after
//
// One command per cycle sustained while results are popped; a result is registered
// into the result queue as its command is taken from the command queue, through
// the back end.
// The back end computes each cursor update combinationally, which sets the rate.
// Synchronous reset clears the cursor, string flags and both queues.
// A stalled result side backs up the two-entry queues, then raises full.
module text_console_cursor_engine #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  func,
  input  logic [7:0]  char_code,
  input  logic [7:0]  style,
  input  logic [7:0]  row,
  input  logic [7:0]  col,
  input  logic        last,
  input  logic        pop,
  output logic        empty,
  output logic [10:0] start_cell,
  output logic [10:0] fill_count,
  output logic [7:0]  cell_char,
  output logic        write_style,
  output logic [7:0]  cell_style,
  output logic [10:0] cursor_after
);
  import tcce_pkg::*;

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(res_t);

  cmd_t             cmd_in;
  logic [CMD_W-1:0] cmd_q;
  cmd_t             cmd_out;
  logic             cmd_empty;
  res_t             res_in;
  logic [RES_W-1:0] res_q;
  res_t             res_out;
  logic             res_full;
  logic             take;

  // Decode
  tcce_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
    .func(func), .char_code(char_code), .style(style),
    .row(row), .col(col), .last(last), .cmd(cmd_in)
  );

  // Command queue
  tcce_fifo #(.W(CMD_W)) u_cmd_q (
    .clk(clk), .rst(rst),
    .push(push), .din(CMD_W'(cmd_in)), .full(full),
    .pop(take), .dout(cmd_q), .empty(cmd_empty)
  );

  assign cmd_out = cmd_t'(cmd_q);
  assign take    = !cmd_empty && !res_full;

  // Execute
  tcce_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
    .clk(clk), .rst(rst), .take(take), .cmd(cmd_out), .res(res_in)
  );

  // Result queue
  tcce_fifo #(.W(RES_W)) u_res_q (
    .clk(clk), .rst(rst),
    .push(take), .din(RES_W'(res_in)), .full(res_full),
    .pop(pop), .dout(res_q), .empty(empty)
  );

  assign res_out      = res_t'(res_q);
  assign start_cell   = res_out.start_cell;
  assign fill_count   = res_out.fill_count;
  assign cell_char    = res_out.cell_char;
  assign write_style  = res_out.write_style;
  assign cell_style   = res_out.cell_style;
  assign cursor_after = res_out.cursor_after;

`ifndef SYNTHESIS
  a_reset_clears: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not cleared by reset");
  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && fill_count == 11'd0) |-> (start_cell == 11'd0 && !write_style))
    else $error("empty run carries write fields");
  a_styled_single: assert property (@(posedge clk) disable iff (rst)
    (!empty && write_style) |-> (fill_count == 11'd1))
    else $error("styled write longer than one cell");
`endif
endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the text console cursor engine.
`timescale 1ns / 1ps

module testbench;
  import tcce_pkg::*;

  localparam int SCREEN_COLS  = 80;
  localparam int SCREEN_ROWS  = 25;
  localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;
  localparam int IDLE_PCT     = 27;
  localparam int MAX_SHOWN    = 10;
  localparam int RANDOM_ITEMS = 1000;
  localparam int TAIL_CYCLES  = 20;
  localparam int CYCLE_LIMIT  = 400000;

  // Function codes the block treats as no-ops.
  localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

  // Cursor predictor plus the queue of cell writes still owed by the block.
  class console_scoreboard;
    int unsigned cur_cell;
    int unsigned home_cell;
    bit          pos_open;
    bit          string_dropped;
    res_t        word;
    res_t        owed_writes[$];
    int          mismatches;

    function new();
      cur_cell       = 0;
      home_cell      = 0;
      pos_open       = 1'b0;
      string_dropped = 1'b0;
      mismatches     = 0;
    endfunction

    function int pending();
      return owed_writes.size();
    endfunction

    // Close an open string: positioned restores, styled wraps at screen end.
    function void end_string();
      if (pos_open) begin
        cur_cell = home_cell;
      end else if (cur_cell >= SCREEN_CELLS) begin
        cur_cell = 0;
      end
      pos_open       = 1'b0;
      string_dropped = 1'b0;
    endfunction

    function void write_run(int unsigned first, int unsigned count, logic [7:0] ch,
                            logic ws, logic [7:0] sty);
      word.start_cell  = first[10:0];
      word.fill_count  = count[10:0];
      word.cell_char   = ch;
      word.write_style = ws;
      word.cell_style  = ws ? sty : 8'h00;
    endfunction

    // Styled char: dropped once the string has run off the screen.
    function void put_styled(logic [7:0] ch, logic [7:0] sty);
      if (string_dropped || cur_cell >= SCREEN_CELLS) begin
        string_dropped = 1'b1;
        return;
      end
      write_run(cur_cell, 1, ch, 1'b1, sty);
      cur_cell++;
      if (cur_cell >= SCREEN_CELLS) string_dropped = 1'b1;
    endfunction

    function void note_command(logic [2:0] f, logic [7:0] ch, logic [7:0] sty,
                               logic [7:0] r, logic [7:0] c, logic l);
      int unsigned span;
      word = '0;
      case (f)
        FUNC_PLAIN: begin
          end_string();
          if (ch == CHAR_BS) begin
            if (cur_cell > 0) begin
              cur_cell--;
              write_run(cur_cell, 1, CHAR_NUL, 1'b0, 8'h00);
            end
          end else if (ch == CHAR_NL) begin
            span = SCREEN_COLS - (cur_cell % SCREEN_COLS);
            write_run(cur_cell, span, CHAR_SPACE, 1'b0, 8'h00);
            cur_cell += span;
          end else begin
            write_run(cur_cell, 1, ch, 1'b0, 8'h00);
            cur_cell++;
          end
          if (cur_cell >= SCREEN_CELLS) cur_cell = 0;
        end
        FUNC_STYLED: begin
          if (pos_open) end_string();
          put_styled(ch, sty);
          if (l) end_string();
        end
        FUNC_POS: begin
          // Row and col only count on the first char of the string.
          if (!pos_open) begin
            end_string();
            home_cell = cur_cell;
            pos_open  = 1'b1;
            if (int'(r) < SCREEN_ROWS && int'(c) < SCREEN_COLS) begin
              cur_cell = int'(r) * SCREEN_COLS + int'(c);
            end else begin
              string_dropped = 1'b1;
            end
          end
          put_styled(ch, sty);
          if (l) end_string();
        end
        FUNC_SETCUR: begin
          end_string();
          if (int'(r) < SCREEN_ROWS && int'(c) < SCREEN_COLS) begin
            cur_cell = int'(r) * SCREEN_COLS + int'(c);
          end
        end
        FUNC_CLEAR: begin
          end_string();
          write_run(0, SCREEN_CELLS, CHAR_SPACE, 1'b0, 8'h00);
          cur_cell = 0;
        end
        default: begin
        end
      endcase
      word.cursor_after = cur_cell[10:0];
      owed_writes.push_back(word);
    endfunction

    function void flag(string what, int unsigned want, int unsigned got);
      mismatches++;
      if (mismatches <= MAX_SHOWN) begin
        $display("[%0t] %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
      end
    endfunction

    function void field(string what, int unsigned want, int unsigned got);
      if (want != got) flag(what, want, got);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (owed_writes.size() == 0) begin
        flag("unexpected word, start_cell", 0, got.start_cell);
        return;
      end
      want = owed_writes.pop_front();
      field("start_cell", want.start_cell, got.start_cell);
      field("fill_count", want.fill_count, got.fill_count);
      field("cell_char", want.cell_char, got.cell_char);
      field("write_style", want.write_style, got.write_style);
      field("cell_style", want.cell_style, got.cell_style);
      field("cursor_after", want.cursor_after, got.cursor_after);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [2:0]  func = FUNC_PLAIN;
  logic [7:0]  char_code = 8'h00;
  logic [7:0]  style = 8'h00;
  logic [7:0]  row = 8'h00;
  logic [7:0]  col = 8'h00;
  logic        last = 1'b0;
  logic        pop = 1'b0;
  logic        empty;
  logic [10:0] start_cell;
  logic [10:0] fill_count;
  logic [7:0]  cell_char;
  logic        write_style;
  logic [7:0]  cell_style;
  logic [10:0] cursor_after;

  console_scoreboard model = new();
  bit quiet = 1'b0;
  int sent = 0;
  int cycles = 0;

  text_console_cursor_engine #(
    .COLUMNS(SCREEN_COLS),
    .ROWS   (SCREEN_ROWS)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .func        (func),
    .char_code   (char_code),
    .style       (style),
    .row         (row),
    .col         (col),
    .last        (last),
    .pop         (pop),
    .empty       (empty),
    .start_cell  (start_cell),
    .fill_count  (fill_count),
    .cell_char   (cell_char),
    .write_style (write_style),
    .cell_style  (cell_style),
    .cursor_after(cursor_after)
  );

  always #1 clk = ~clk;

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: random pop stalls, check each word taken.
  initial begin
    res_t got;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        got.start_cell   = start_cell;
        got.fill_count   = fill_count;
        got.cell_char    = cell_char;
        got.write_style  = write_style;
        got.cell_style   = cell_style;
        got.cursor_after = cursor_after;
        model.check_result(got);
      end
      pop <= !rst && (quiet || $urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // One command: random idle cycles with junk on func and char_code, then hold until taken.
  task automatic send_cmd(input logic [2:0] f, input logic [7:0] ch, input logic [7:0] sty,
                          input logic [7:0] r, input logic [7:0] c, input logic l);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      push      <= 1'b0;
      func      <= 3'($urandom);
      char_code <= 8'($urandom);
      @(posedge clk);
    end
    push      <= 1'b1;
    func      <= f;
    char_code <= ch;
    style     <= sty;
    row       <= r;
    col       <= c;
    last      <= l;
    @(posedge clk);
    while (full) @(posedge clk);
    model.note_command(f, ch, sty, r, c, l);
    sent++;
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (model.pending() != 0) @(posedge clk);
  endtask

  task automatic set_cursor(input logic [7:0] r, input logic [7:0] c);
    send_cmd(FUNC_SETCUR, 8'($urandom), 8'($urandom), r, c, 1'($urandom));
  endtask

  task automatic set_cursor_near_end();
    set_cursor(8'(SCREEN_ROWS - 1), 8'($urandom_range(SCREEN_COLS - 12, SCREEN_COLS - 1)));
  endtask

  // Plain run with backspaces and newlines mixed in.
  task automatic plain_run(input int len);
    int pick;
    logic [7:0] ch;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 99);
      ch = (pick < 15) ? CHAR_BS : (pick < 25) ? CHAR_NL : 8'($urandom);
      send_cmd(FUNC_PLAIN, ch, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
    end
  endtask

  // Styled or positioned string; left open when closed is 0.
  task automatic string_run(input logic [2:0] f, input logic [7:0] r, input logic [7:0] c,
                            input int len, input bit closed);
    for (int i = 0; i < len; i++) begin
      send_cmd(f, 8'($urandom), 8'($urandom), (i == 0) ? r : 8'($urandom),
               (i == 0) ? c : 8'($urandom), closed && (i == len - 1));
    end
  endtask

  task automatic random_row_col(output logic [7:0] r, output logic [7:0] c);
    if ($urandom_range(0, 99) < 80) begin
      r = 8'($urandom_range(0, SCREEN_ROWS - 1));
      c = 8'($urandom_range(0, SCREEN_COLS - 1));
    end else begin
      r = 8'($urandom);
      c = 8'($urandom);
    end
  endtask

  initial begin
    int pick;
    int goal;
    logic [7:0] r;
    logic [7:0] c;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: specials at the screen edges.
    send_cmd(FUNC_PLAIN, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0);
    send_cmd(FUNC_PLAIN, CHAR_BS, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_cmd(FUNC_PLAIN, CHAR_BS, 8'h00, 8'h00, 8'h00, 1'b0);        // backspace at cell zero
    send_cmd(FUNC_PLAIN, CHAR_NL, 8'h00, 8'h00, 8'h00, 1'b0);
    set_cursor(8'(SCREEN_ROWS - 1), 8'(SCREEN_COLS - 1));
    send_cmd(FUNC_PLAIN, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);          // wraps past last cell
    set_cursor(8'(SCREEN_ROWS - 1), 8'(SCREEN_COLS - 2));
    string_run(FUNC_STYLED, 8'h00, 8'h00, 4, 1'b1);                  // runs off screen end
    set_cursor(8'(SCREEN_ROWS), 8'h00);                              // out of range
    set_cursor(8'h00, 8'(SCREEN_COLS));
    set_cursor(8'hFF, 8'hFF);
    string_run(FUNC_POS, 8'd3, 8'd5, 3, 1'b1);
    string_run(FUNC_POS, 8'd200, 8'h00, 2, 1'b1);                    // positioned out of range
    string_run(FUNC_POS, 8'(SCREEN_ROWS - 1), 8'(SCREEN_COLS - 1), 3, 1'b1);
    string_run(FUNC_STYLED, 8'h00, 8'h00, 1, 1'b0);                  // interrupted by plain
    send_cmd(FUNC_PLAIN, 8'h41, 8'h00, 8'h00, 8'h00, 1'b0);
    string_run(FUNC_POS, 8'd10, 8'd40, 1, 1'b0);                     // interrupted by styled
    string_run(FUNC_STYLED, 8'h00, 8'h00, 1, 1'b1);
    send_cmd(FUNC_SPARE_LO, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_cmd(FUNC_SPARE_HI, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    send_cmd(FUNC_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);

    // Hold the sender until the block has handed back everything.
    drain();

    // Random: mostly well-formed strings, some broken ones and noise.
    goal = sent + RANDOM_ITEMS;
    while (sent < goal) begin
      quiet = (goal - sent) < 600 && (goal - sent) > 400;
      if ((goal - sent) == RANDOM_ITEMS / 4) drain();
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        plain_run($urandom_range(1, 6));
      end else if (pick < 50) begin
        if ($urandom_range(0, 99) < 30) set_cursor_near_end();
        string_run(FUNC_STYLED, 8'($urandom), 8'($urandom), $urandom_range(1, 8),
                   $urandom_range(0, 99) < 85);
      end else if (pick < 70) begin
        random_row_col(r, c);
        if ($urandom_range(0, 99) < 20) r = 8'(SCREEN_ROWS - 1);
        string_run(FUNC_POS, r, c, $urandom_range(1, 6), $urandom_range(0, 99) < 85);
      end else if (pick < 85) begin
        if ($urandom_range(0, 1) == 0) begin
          set_cursor_near_end();
        end else begin
          random_row_col(r, c);
          set_cursor(r, c);
        end
      end else if (pick < 90) begin
        send_cmd(FUNC_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 1'($urandom));
      end else if (pick < 94) begin
        send_cmd(3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI)), 8'($urandom),
                 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
      end else begin
        set_cursor(8'($urandom), 8'($urandom));
      end
    end
    quiet = 1'b0;

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (model.mismatches == 0 && model.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/tcce_pkg.sv
rtl/tcce_fifo.sv
rtl/tcce_front.sv
rtl/tcce_back.sv
rtl/text_console_cursor_engine.sv
tb/testbench.sv
